// ----- hw/rtl/oerb_pkg.sv -----
// oerb_pkg: shared codes, field widths and state types for the ordered event
// reorder buffer. No dependencies.

package oerb_pkg;

    // Width of the explicit sequence field on the input bus
    localparam int EXPL_BITS     = 7;
    // Largest sequence width the design supports
    localparam int SEQ_BITS_MAX  = 12;
    // Input sideband layout (s_tuser)
    localparam int TUSER_IN_BITS = 4;

    // seq_mode codes
    typedef enum logic [1:0] {
        MODE_FOLLOW    = 2'd0,
        MODE_EXPLICIT  = 2'd1,
        MODE_UNORDERED = 2'd2,
        MODE_RESERVED  = 2'd3
    } seq_mode_t;

    // Back-end sequencer states
    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_DRAIN = 1'b1
    } back_state_t;

endpackage

// ----- hw/rtl/oerb_front.sv -----
// oerb_front: accepts event transactions, tracks the previous sequence and
// classifies each event into an ordered or pass-through command. Uses oerb_pkg.

module oerb_front #(
    parameter int SEQ_BITS    = 7,
    parameter int HANDLE_BITS = 16,
    parameter int TDATA_BITS  = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [TDATA_BITS-1:0]                s_tdata,
    input  logic [oerb_pkg::TUSER_IN_BITS-1:0]   s_tuser,
    output logic                                 cmd_valid,
    input  logic                                 cmd_ready,
    output logic [SEQ_BITS+HANDLE_BITS:0]        cmd_data
);

    localparam logic [SEQ_BITS-1:0] PREV_AT_PACKET = SEQ_BITS'((1 << SEQ_BITS) - 4);
    localparam logic [SEQ_BITS-1:0] PREV_UNORDERED = SEQ_BITS'((1 << SEQ_BITS) - 2);

    logic [SEQ_BITS-1:0]               prev_reg;
    logic [SEQ_BITS-1:0]               prev_next;
    logic [SEQ_BITS-1:0]               prev_eff;
    logic [SEQ_BITS-1:0]               seq;
    logic                              ordered;
    logic                              accept;
    logic                              packet_start;
    logic                              guaranteed;
    oerb_pkg::seq_mode_t               mode;
    logic [oerb_pkg::SEQ_BITS_MAX-1:0] expl_ext;
    logic [HANDLE_BITS-1:0]            handle;

    assign packet_start = s_tuser[0];
    assign guaranteed   = s_tuser[1];
    assign mode         = oerb_pkg::seq_mode_t'(s_tuser[3:2]);
    assign expl_ext     = {{(oerb_pkg::SEQ_BITS_MAX - oerb_pkg::EXPL_BITS){1'b0}},
                           s_tdata[oerb_pkg::EXPL_BITS-1:0]};
    assign handle       = s_tdata[oerb_pkg::EXPL_BITS +: HANDLE_BITS];

    assign s_tready  = cmd_ready;
    assign cmd_valid = s_tvalid;
    assign accept    = s_tvalid && cmd_ready;

    // packet start rewinds the previous sequence before the event is classified
    assign prev_eff = packet_start ? PREV_AT_PACKET : prev_reg;

    always_comb begin
        seq       = prev_eff;
        ordered   = 1'b0;
        prev_next = prev_eff;
        if (guaranteed) begin
            unique case (mode) inside
                oerb_pkg::MODE_FOLLOW: begin
                    seq       = prev_eff + 1'b1;
                    ordered   = 1'b1;
                    prev_next = seq;
                end
                oerb_pkg::MODE_EXPLICIT: begin
                    seq       = expl_ext[SEQ_BITS-1:0];
                    ordered   = 1'b1;
                    prev_next = seq;
                end
                oerb_pkg::MODE_UNORDERED, oerb_pkg::MODE_RESERVED: begin
                    prev_next = PREV_UNORDERED;
                end
            endcase
        end
    end

    assign cmd_data = {ordered, seq, handle};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= PREV_AT_PACKET;
        end else if (accept) begin
            prev_reg <= prev_next;
        end
    end

endmodule

// ----- hw/rtl/oerb_queue.sv -----
// oerb_queue: two-entry command queue between the front and back ends.
// No package dependencies.

module oerb_queue #(
    parameter int WIDTH = 24
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ----- hw/rtl/oerb_back.sv -----
// oerb_back: executes queued commands: window check, slot store, in-order
// delivery and drain of held events into the output register. Uses oerb_pkg.

module oerb_back #(
    parameter int SEQ_BITS    = 7,
    parameter int WINDOW      = 64,
    parameter int HANDLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic [SEQ_BITS+HANDLE_BITS:0] cmd_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [HANDLE_BITS-1:0]        out_handle,
    output logic                          out_dropped,
    output logic                          out_last
);

    localparam int SLOTS = 1 << SEQ_BITS;

    // handle store, reset value undefined; valid bits live in flops
    logic [HANDLE_BITS-1:0] mem [SLOTS];
    logic [HANDLE_BITS-1:0] rd_data_reg;

    oerb_pkg::back_state_t  state_reg, state_next;
    logic [SEQ_BITS-1:0]    ne_reg, ne_next;
    logic [SLOTS-1:0]       valid_reg, valid_next;
    logic                   out_valid_reg, out_valid_next;
    logic [HANDLE_BITS-1:0] out_handle_reg, out_handle_next;
    logic                   out_dropped_reg, out_dropped_next;
    logic                   out_last_reg, out_last_next;

    logic                   out_free;
    logic                   load;
    logic                   wr_en;
    logic                   rd_en;
    logic                   cmd_ordered;
    logic [SEQ_BITS-1:0]    cmd_seq;
    logic [HANDLE_BITS-1:0] cmd_handle;
    logic [SEQ_BITS-1:0]    ne_inc;
    logic [SEQ_BITS-1:0]    seq_dist;
    logic                   far;

    assign cmd_ordered = cmd_data[SEQ_BITS+HANDLE_BITS];
    assign cmd_seq     = cmd_data[HANDLE_BITS +: SEQ_BITS];
    assign cmd_handle  = cmd_data[HANDLE_BITS-1:0];

    assign out_free = !out_valid_reg || out_ready;
    assign ne_inc   = ne_reg + 1'b1;
    assign seq_dist = cmd_seq - ne_reg;
    assign far      = {{(32 - SEQ_BITS){1'b0}}, seq_dist} >= 32'(WINDOW);

    always_comb begin
        state_next       = state_reg;
        ne_next          = ne_reg;
        valid_next       = valid_reg;
        load             = 1'b0;
        out_handle_next  = out_handle_reg;
        out_dropped_next = 1'b0;
        out_last_next    = 1'b1;
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        cmd_ready        = 1'b0;
        unique case (state_reg)
            oerb_pkg::ST_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_ready = 1'b1;
                    if (!cmd_ordered) begin
                        load            = 1'b1;
                        out_handle_next = cmd_handle;
                    end else if (far) begin
                        load             = 1'b1;
                        out_handle_next  = cmd_handle;
                        out_dropped_next = 1'b1;
                    end else if (seq_dist != '0) begin
                        wr_en               = 1'b1;
                        valid_next[cmd_seq] = 1'b1;
                    end else begin
                        load            = 1'b1;
                        out_handle_next = cmd_handle;
                        ne_next         = ne_inc;
                        if (valid_reg[ne_inc]) begin
                            out_last_next = 1'b0;
                            rd_en         = 1'b1;
                            state_next    = oerb_pkg::ST_DRAIN;
                        end
                    end
                end
            end
            oerb_pkg::ST_DRAIN: begin
                // rd_data_reg holds the handle of slot ne_reg
                if (out_free) begin
                    load               = 1'b1;
                    out_handle_next    = rd_data_reg;
                    valid_next[ne_reg] = 1'b0;
                    ne_next            = ne_inc;
                    if (valid_reg[ne_inc]) begin
                        out_last_next = 1'b0;
                        rd_en         = 1'b1;
                    end else begin
                        state_next = oerb_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = oerb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[cmd_seq] <= cmd_handle;
        end
        if (rd_en) begin
            rd_data_reg <= mem[ne_inc];
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_handle_reg  <= out_handle_next;
            out_dropped_reg <= out_dropped_next;
            out_last_reg    <= out_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= oerb_pkg::ST_IDLE;
            ne_reg        <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ne_reg        <= ne_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_handle  = out_handle_reg;
    assign out_dropped = out_dropped_reg;
    assign out_last    = out_last_reg;

    // drain only ever reads a held slot
    a_drain_slot_held: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == oerb_pkg::ST_DRAIN |-> valid_reg[ne_reg])
        else $error("drain on empty slot");

    // a non-final result is always followed by the drain sequencer
    a_notlast_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        load && !out_last_next |=> state_reg == oerb_pkg::ST_DRAIN)
        else $error("non-final result without drain");

    // a held event never lands on the expected slot
    a_hold_not_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> cmd_seq != ne_reg)
        else $error("hold at expected sequence");

    // a drop flag is always the only result of its event
    a_drop_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        load && out_dropped_next |-> out_last_next && state_reg == oerb_pkg::ST_IDLE)
        else $error("drop not a single result");

endmodule

// ----- hw/rtl/ordered_event_reorder_buffer_unit.sv -----
// ordered_event_reorder_buffer_unit: top level of the in-order event reorder buffer.
// Instantiates oerb_front, oerb_queue and oerb_back; uses oerb_pkg.
//
//  channel | dir | tdata (low bit up)                   | tuser (low bit up)           | tlast
//  s_      | in  | explicit_seq[6:0], event_handle      | packet_start, guaranteed,    | -
//          |     |                                      | seq_mode[1:0]                |
//  m_      | out | out_handle                           | dropped                      | last
//
// Flow: accepted events pass a queue entry, then the output register, to reach m_. While
// idle with a free output register the back end takes one command per cycle; an in-order
// event that releases n held events yields n+1 transactions, one per cycle while m_tready
// is high, paced by the single read port of the handle store and the output register.
// Reset: synchronous; slot valid bits clear in the reset cycle, no clearing pass.
// Stalls: m_tready low holds the output register; the two-entry queue then fills and
// s_tready drops until the back end moves again.

module ordered_event_reorder_buffer_unit #(
    parameter int SEQ_BITS    = 7,
    parameter int WINDOW      = 64,
    parameter int HANDLE_BITS = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    // slave side: explicit_seq, event_handle, zero padding
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    input  logic [((oerb_pkg::EXPL_BITS + HANDLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // slave sideband: packet_start, guaranteed, seq_mode[1:0]
    input  logic [oerb_pkg::TUSER_IN_BITS-1:0]            s_tuser,
    // master side: out_handle, zero padding
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    output logic [((HANDLE_BITS + 7) / 8) * 8 - 1:0]      m_tdata,
    // master sideband: dropped
    output logic [0:0]                                    m_tuser,
    output logic                                          m_tlast
);

    localparam int S_TDATA_BITS = ((oerb_pkg::EXPL_BITS + HANDLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((HANDLE_BITS + 7) / 8) * 8;
    localparam int CMD_W        = 1 + SEQ_BITS + HANDLE_BITS;

    // front -> queue
    logic             fq_valid;
    logic             fq_ready;
    logic [CMD_W-1:0] fq_data;
    // queue -> back
    logic             qb_valid;
    logic             qb_ready;
    logic [CMD_W-1:0] qb_data;

    logic [HANDLE_BITS-1:0] out_handle;
    logic                   out_dropped;

    // front: sequence tracking and classification
    oerb_front #(
        .SEQ_BITS    (SEQ_BITS),
        .HANDLE_BITS (HANDLE_BITS),
        .TDATA_BITS  (S_TDATA_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd_data  (fq_data)
    );

    // decoupling queue, lets the front keep accepting during a drain
    oerb_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    // back: window check, slot store, in-order delivery and drain
    oerb_back #(
        .SEQ_BITS    (SEQ_BITS),
        .WINDOW      (WINDOW),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (qb_valid),
        .cmd_ready   (qb_ready),
        .cmd_data    (qb_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_handle  (out_handle),
        .out_dropped (out_dropped),
        .out_last    (m_tlast)
    );

    assign m_tdata = M_TDATA_BITS'(out_handle);
    assign m_tuser = out_dropped;

endmodule
